[rtl/rtw_pkg.sv]
// ----------------------------------------------------------------------------
// rtw_pkg
// Shared types, codes and sizes for the reservation table with timing wheel.
// ----------------------------------------------------------------------------
`default_nettype none

package rtw_pkg;

   localparam int TABLE_ENTRIES_DEF = 32;
   localparam int WHEEL_SLOTS       = 64;
   localparam int WHEEL_BITS        = $clog2(WHEEL_SLOTS);
   localparam int LAP_BITS          = 32 - WHEEL_BITS;

   localparam logic [1:0] CMD_CREATE = 2'd0;
   localparam logic [1:0] CMD_CANCEL = 2'd1;
   localparam logic [1:0] CMD_TICK   = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam logic [2:0] RC_OK       = 3'd0;
   localparam logic [2:0] RC_FULL     = 3'd1;
   localparam logic [2:0] RC_BAD_TIME = 3'd2;
   localparam logic [2:0] RC_CONFLICT = 3'd3;
   localparam logic [2:0] RC_REFUSED  = 3'd4;

   localparam logic [1:0] EV_NONE     = 2'd0;
   localparam logic [1:0] EV_RESERVED = 2'd1;
   localparam logic [1:0] EV_AVAIL    = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [31:0]           id;
      logic [15:0]           device;
      logic [15:0]           user;
      logic [31:0]           start_sec;
      logic [31:0]           end_sec;
      logic [LAP_BITS-1:0]   laps;
      logic [WHEEL_BITS-1:0] bucket;
   } entry_type;

endpackage

`default_nettype wire

[rtl/rtw_if.sv]
// ----------------------------------------------------------------------------
// rtw_req_if / rtw_rsp_if
// Valid/ready channels carrying requests and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface rtw_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [15:0] device;
   logic [15:0] user;
   logic [31:0] start_sec;
   logic [31:0] end_sec;
   logic [31:0] now;
   logic [31:0] target_id;

   modport source (output valid, cmd, device, user, start_sec, end_sec, now,
                   target_id, input ready);
   modport sink   (input valid, cmd, device, user, start_sec, end_sec, now,
                   target_id, output ready);
endinterface

interface rtw_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  code;
   logic [31:0] assigned_id;
   logic [15:0] device_out;
   logic [1:0]  device_event;
   logic        last;

   modport source (output valid, code, assigned_id, device_out, device_event, last,
                   input ready);
   modport sink   (input valid, code, assigned_id, device_out, device_event, last,
                   output ready);
endinterface

`default_nettype wire

[rtl/reservation_table_with_timing_wheel_top.sv]
// ----------------------------------------------------------------------------
// reservation_table_with_timing_wheel_top
// Reservation table filed in a hashed timing wheel: create, cancel, tick.
// ----------------------------------------------------------------------------
// Usage:
//  - req_chan carries one request (create, cancel or tick); rsp_chan returns
//    its results, the final one flagged by last. A tick returns one result per
//    expired entry in table order, then a closing result.
//  - Entry payloads live in a single-port-write memory with a registered read;
//    valid and cancelled flags sit in flip-flops. Each create, cancel and tick
//    walks the table at most once through the read register, one entry per
//    cycle unless a stalled tick holds on an expired entry.
//  - A create that fails the room or time check skips the walk and goes
//    straight to its final result, and a cancel stops the walk at its match.
//  - One request is in flight at a time; req_chan.ready is high only while
//    idle, so a new request is taken only after the last one is done. Results
//    sit in an output register; the final result must enter it before the
//    next request is taken.
//  - When the receiver stalls, hold the walk on an expired entry (re-reading
//    it) or hold the final result until the output register frees up.
//  - Synchronous reset empties the table, parks the wheel at slot 0 and sets
//    the next id to 1. No memory clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module reservation_table_with_timing_wheel_top #(
   parameter int TABLE_ENTRIES = rtw_pkg::TABLE_ENTRIES_DEF
) (
   input  wire        clock,
   input  wire        reset,
   rtw_req_if.sink    req_chan,
   rtw_rsp_if.source  rsp_chan
);

   localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int PW = $clog2(TABLE_ENTRIES + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(TABLE_ENTRIES);
   localparam int WB = rtw_pkg::WHEEL_BITS;

   // control state
   rtw_pkg::state_type state_ff, state_in;
   logic [PW-1:0]            ptr_ff, ptr_in;
   logic                     ev_vld_ff, ev_vld_in;
   logic [IW-1:0]            ev_idx_ff, ev_idx_in;
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic [TABLE_ENTRIES-1:0] canc_ff, canc_in;
   logic [PW-1:0]            occ_ff, occ_in;
   logic [WB-1:0]            wp_ff, wp_in;
   logic [31:0]              nid_ff, nid_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   // per-request scratch
   logic [2:0]    fail_ff, fail_in;
   logic          conflict_ff, conflict_in;
   logic          found_free_ff, found_free_in;
   logic [IW-1:0] free_ix_ff, free_ix_in;
   logic          cancel_ok_ff, cancel_ok_in;
   logic [15:0]   keep_dev_ff, keep_dev_in;

   // latched request
   logic [1:0]  cmd_ff, cmd_in;
   logic [15:0] dev_ff, dev_in;
   logic [15:0] user_ff, user_in;
   logic [31:0] st_ff, st_in;
   logic [31:0] en_ff, en_in;
   logic [31:0] now_ff, now_in;
   logic [31:0] rid_ff, rid_in;

   // result register
   logic [2:0]  code_ff, code_in;
   logic [31:0] aid_ff, aid_in;
   logic [15:0] dout_ff, dout_in;
   logic [1:0]  dev_ev_ff, dev_ev_in;
   logic        last_ff, last_in;

   // entry memory
   rtw_pkg::entry_type mem [TABLE_ENTRIES];
   rtw_pkg::entry_type mem_q;
   rtw_pkg::entry_type mem_wd;
   logic               mem_we;
   logic [IW-1:0]      mem_wa;
   logic [IW-1:0]      rd_addr;

   logic        out_free;
   logic        advance;
   logic        stop;
   logic        hit;
   logic [31:0] rem;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      mem_q <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rtw_pkg::ST_IDLE;
         ptr_ff       <= '0;
         ev_vld_ff    <= 1'b0;
         valid_ff     <= '0;
         canc_ff      <= '0;
         occ_ff       <= '0;
         wp_ff        <= '0;
         nid_ff       <= 32'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         ev_vld_ff    <= ev_vld_in;
         valid_ff     <= valid_in;
         canc_ff      <= canc_in;
         occ_ff       <= occ_in;
         wp_ff        <= wp_in;
         nid_ff       <= nid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ev_idx_ff     <= ev_idx_in;
      fail_ff       <= fail_in;
      conflict_ff   <= conflict_in;
      found_free_ff <= found_free_in;
      free_ix_ff    <= free_ix_in;
      cancel_ok_ff  <= cancel_ok_in;
      keep_dev_ff   <= keep_dev_in;
      cmd_ff        <= cmd_in;
      dev_ff        <= dev_in;
      user_ff       <= user_in;
      st_ff         <= st_in;
      en_ff         <= en_in;
      now_ff        <= now_in;
      rid_ff        <= rid_in;
      code_ff       <= code_in;
      aid_ff        <= aid_in;
      dout_ff       <= dout_in;
      dev_ev_ff     <= dev_ev_in;
      last_ff       <= last_in;
   end

   always_comb begin
      state_in      = state_ff;
      ptr_in        = ptr_ff;
      ev_vld_in     = ev_vld_ff;
      ev_idx_in     = ev_idx_ff;
      valid_in      = valid_ff;
      canc_in       = canc_ff;
      occ_in        = occ_ff;
      wp_in         = wp_ff;
      nid_in        = nid_ff;
      fail_in       = fail_ff;
      conflict_in   = conflict_ff;
      found_free_in = found_free_ff;
      free_ix_in    = free_ix_ff;
      cancel_ok_in  = cancel_ok_ff;
      keep_dev_in   = keep_dev_ff;
      cmd_in        = cmd_ff;
      dev_in        = dev_ff;
      user_in       = user_ff;
      st_in         = st_ff;
      en_in         = en_ff;
      now_in        = now_ff;
      rid_in        = rid_ff;
      code_in       = code_ff;
      aid_in        = aid_ff;
      dout_in       = dout_ff;
      dev_ev_in     = dev_ev_ff;
      last_in       = last_ff;
      mem_we        = 1'b0;
      mem_wa        = ev_idx_ff;
      mem_wd        = mem_q;
      rd_addr       = ev_idx_ff;
      advance       = 1'b1;
      stop          = 1'b0;
      rem           = en_ff - now_ff;

      // drop the result register once the receiver takes it
      out_free      = !rsp_valid_ff || rsp_chan.ready;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      hit           = ev_vld_ff && valid_ff[ev_idx_ff];

      case (state_ff)
         rtw_pkg::ST_IDLE: begin
            if (req_chan.valid) begin
               cmd_in        = req_chan.cmd;
               dev_in        = req_chan.device;
               user_in       = req_chan.user;
               st_in         = req_chan.start_sec;
               en_in         = req_chan.end_sec;
               now_in        = req_chan.now;
               rid_in        = req_chan.target_id;
               fail_in       = rtw_pkg::RC_OK;
               conflict_in   = 1'b0;
               found_free_in = 1'b0;
               cancel_ok_in  = 1'b0;
               ptr_in        = '0;
               ev_vld_in     = 1'b0;
               case (req_chan.cmd)
                  rtw_pkg::CMD_CREATE: begin
                     if (occ_ff >= LAST_PTR) begin
                        fail_in  = rtw_pkg::RC_FULL;
                        state_in = rtw_pkg::ST_FINISH;
                     end else if (req_chan.start_sec >= req_chan.end_sec ||
                                  req_chan.start_sec < req_chan.now) begin
                        fail_in  = rtw_pkg::RC_BAD_TIME;
                        state_in = rtw_pkg::ST_FINISH;
                     end else begin
                        state_in = rtw_pkg::ST_SCAN;
                     end
                  end
                  rtw_pkg::CMD_CANCEL: begin
                     state_in = rtw_pkg::ST_SCAN;
                  end
                  rtw_pkg::CMD_TICK: begin
                     wp_in    = wp_ff + 1'b1;
                     state_in = rtw_pkg::ST_SCAN;
                  end
                  default: begin
                     state_in = rtw_pkg::ST_FINISH;
                  end
               endcase
            end
         end

         rtw_pkg::ST_SCAN: begin
            case (cmd_ff)
               rtw_pkg::CMD_CREATE: begin
                  if (hit && !canc_ff[ev_idx_ff] && mem_q.device == dev_ff &&
                      en_ff > mem_q.start_sec && st_ff < mem_q.end_sec) begin
                     conflict_in = 1'b1;
                  end
                  if (ev_vld_ff && !valid_ff[ev_idx_ff] && !found_free_ff) begin
                     found_free_in = 1'b1;
                     free_ix_in    = ev_idx_ff;
                  end
               end
               rtw_pkg::CMD_CANCEL: begin
                  if (hit && mem_q.id == rid_ff) begin
                     // first match decides, stop the walk here
                     stop     = 1'b1;
                     state_in = rtw_pkg::ST_FINISH;
                     if (!canc_ff[ev_idx_ff] && mem_q.user == user_ff) begin
                        canc_in[ev_idx_ff] = 1'b1;
                        cancel_ok_in       = 1'b1;
                        keep_dev_in        = mem_q.device;
                     end
                  end
               end
               rtw_pkg::CMD_TICK: begin
                  if (hit && mem_q.bucket == wp_ff) begin
                     if (canc_ff[ev_idx_ff]) begin
                        valid_in[ev_idx_ff] = 1'b0;
                        canc_in[ev_idx_ff]  = 1'b0;
                        occ_in              = occ_ff - 1'b1;
                     end else if (mem_q.laps == '0 && mem_q.end_sec <= now_ff) begin
                        if (out_free) begin
                           valid_in[ev_idx_ff] = 1'b0;
                           occ_in              = occ_ff - 1'b1;
                           rsp_valid_in        = 1'b1;
                           code_in             = rtw_pkg::RC_OK;
                           aid_in              = mem_q.id;
                           dout_in             = mem_q.device;
                           dev_ev_in           = rtw_pkg::EV_AVAIL;
                           last_in             = 1'b0;
                        end else begin
                           // hold on this entry until the result slot frees
                           advance = 1'b0;
                        end
                     end else if (mem_q.laps != '0) begin
                        mem_we      = 1'b1;
                        mem_wd.laps = mem_q.laps - 1'b1;
                     end else begin
                        mem_we        = 1'b1;
                        mem_wd.bucket = wp_ff + 1'b1;
                     end
                  end
               end
               default: begin
                  stop     = 1'b1;
                  state_in = rtw_pkg::ST_FINISH;
               end
            endcase

            if (!ev_vld_ff && ptr_ff == LAST_PTR) begin
               state_in = rtw_pkg::ST_FINISH;
            end

            if (advance) begin
               rd_addr = (ptr_ff < LAST_PTR) ? ptr_ff[IW-1:0] : '0;
               if (!stop) begin
                  ev_vld_in = ptr_ff < LAST_PTR;
                  ev_idx_in = ptr_ff[IW-1:0];
                  if (ptr_ff < LAST_PTR) begin
                     ptr_in = ptr_ff + 1'b1;
                  end
               end
            end
         end

         rtw_pkg::ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               code_in      = rtw_pkg::RC_OK;
               aid_in       = '0;
               dout_in      = '0;
               dev_ev_in    = rtw_pkg::EV_NONE;
               last_in      = 1'b1;
               ev_vld_in    = 1'b0;
               state_in     = rtw_pkg::ST_IDLE;
               case (cmd_ff)
                  rtw_pkg::CMD_CREATE: begin
                     if (fail_ff != rtw_pkg::RC_OK) begin
                        code_in = fail_ff;
                     end else if (conflict_ff) begin
                        code_in = rtw_pkg::RC_CONFLICT;
                     end else if (!found_free_ff) begin
                        code_in = rtw_pkg::RC_FULL;
                     end else begin
                        mem_we              = 1'b1;
                        mem_wa              = free_ix_ff;
                        mem_wd.id           = nid_ff;
                        mem_wd.device       = dev_ff;
                        mem_wd.user         = user_ff;
                        mem_wd.start_sec    = st_ff;
                        mem_wd.end_sec      = en_ff;
                        mem_wd.laps         = rem[31:WB];
                        mem_wd.bucket       = wp_ff + rem[WB-1:0];
                        valid_in[free_ix_ff] = 1'b1;
                        canc_in[free_ix_ff]  = 1'b0;
                        occ_in              = occ_ff + 1'b1;
                        nid_in              = nid_ff + 1'b1;
                        aid_in              = nid_ff;
                        dout_in             = dev_ff;
                        dev_ev_in           = rtw_pkg::EV_RESERVED;
                     end
                  end
                  rtw_pkg::CMD_CANCEL: begin
                     if (cancel_ok_ff) begin
                        aid_in    = rid_ff;
                        dout_in   = keep_dev_ff;
                        dev_ev_in = rtw_pkg::EV_AVAIL;
                     end else begin
                        code_in = rtw_pkg::RC_REFUSED;
                     end
                  end
                  default: begin
                     code_in = rtw_pkg::RC_OK;
                  end
               endcase
            end
         end

         default: begin
            state_in = rtw_pkg::ST_IDLE;
         end
      endcase
   end

   assign req_chan.ready        = (state_ff == rtw_pkg::ST_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.code         = code_ff;
   assign rsp_chan.assigned_id  = aid_ff;
   assign rsp_chan.device_out   = dout_ff;
   assign rsp_chan.device_event = dev_ev_ff;
   assign rsp_chan.last         = last_ff;

endmodule

`default_nettype wire

[rtl/rtw_checker.sv]
// ----------------------------------------------------------------------------
// rtw_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rtw_checker (
   input wire        clock,
   input wire        reset,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire [2:0]  rsp_code,
   input wire [31:0] rsp_assigned_id,
   input wire [15:0] rsp_device_out,
   input wire [1:0]  rsp_device_event,
   input wire        rsp_last
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_code) &&
      $stable(rsp_assigned_id) && $stable(rsp_last))
      else $error("stalled result changed");

   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_code != rtw_pkg::RC_OK |->
      rsp_assigned_id == 32'd0 && rsp_device_out == 16'd0 &&
      rsp_device_event == rtw_pkg::EV_NONE && rsp_last)
      else $error("failure result carries payload");

   a_reserve_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_device_event == rtw_pkg::EV_RESERVED |->
      rsp_code == rtw_pkg::RC_OK && rsp_last)
      else $error("reserved event not a final ok result");

   a_expiry_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |->
      rsp_code == rtw_pkg::RC_OK && rsp_device_event == rtw_pkg::EV_AVAIL)
      else $error("intermediate result is not an expiry");

endmodule

bind reservation_table_with_timing_wheel_top rtw_checker u_rtw_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_code         (rsp_chan.code),
   .rsp_assigned_id  (rsp_chan.assigned_id),
   .rsp_device_out   (rsp_chan.device_out),
   .rsp_device_event (rsp_chan.device_event),
   .rsp_last         (rsp_chan.last)
);

`default_nettype wire
